FILE: src/rv32ex_pkg.sv
package rv32ex_pkg;

    // Instruction classes carried on the input tuser
    localparam logic [2:0] CLS_REG    = 3'd0;
    localparam logic [2:0] CLS_IMM    = 3'd1;
    localparam logic [2:0] CLS_LOAD   = 3'd2;
    localparam logic [2:0] CLS_JALR   = 3'd3;
    localparam logic [2:0] CLS_SYSTEM = 3'd4;
    localparam logic [2:0] CLS_BRANCH = 3'd5;
    localparam logic [2:0] CLS_LUI    = 3'd6;
    localparam logic [2:0] CLS_AUIPC  = 3'd7;

    // ALU funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Load funct3 codes that name no load
    localparam logic [2:0] F3_LD_BAD  = 3'd3;
    localparam logic [2:0] F3_LD_BAD6 = 3'd6;
    localparam logic [2:0] F3_LD_BAD7 = 3'd7;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam int UPPER_SHIFT = 12;
    localparam int XLEN        = 32;
    localparam int SHAMT_W     = 5;

    // Internal operation codes
    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SLL,
        OP_SLT,
        OP_SLTU,
        OP_XOR,
        OP_SRL,
        OP_SRA,
        OP_OR,
        OP_AND,
        OP_BRANCH,
        OP_ZERO
    } t_op;

    typedef logic [XLEN-1:0] t_word;

endpackage

FILE: src/rv32i_execute_unit.sv
// RV32I execute stage, three register stages: decode and operand select, then adder,
// shifter, logic and compares, then result select into the output register. One
// instruction enters per cycle while the pipe is not stalled and each gives exactly
// one result from its input transfer; the whole pipe stalls together only while the output register
// holds a result that the sink does not take. Input tuser is the instruction class,
// output tuser carries the branch-taken and illegal flags; illegal combinations give
// a zero result.
module rv32i_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] funct3, [9:3] funct7, [41:10] src1, [73:42] src2,
    // [105:74] immediate, [137:106] pc_value, [143:138] zero
    input  logic [143:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] result
    output logic [31:0]  m_axis_tdata,
    // [0] branch_taken, [1] illegal
    output logic [1:0]   m_axis_tuser
);
    import rv32ex_pkg::*;

    logic       w_en;
    logic [2:0] w_opcode;
    logic [2:0] w_f3;
    logic [6:0] w_f7;
    t_word      w_src1;
    t_word      w_src2;
    t_word      w_imm;
    t_word      w_pc;
    t_word      w_upper;

    // Stage 1 decode outputs
    t_op   n1_op;
    t_word n1_a;
    t_word n1_b;
    logic  n1_clr0;
    logic  n1_ill;

    logic  r1_v;
    t_op   r1_op;
    t_word r1_a;
    t_word r1_b;
    logic [2:0] r1_f3;
    logic  r1_clr0;
    logic  r1_ill;

    // Stage 2 compute outputs
    t_word n2_val;
    t_word w_sum;
    logic [SHAMT_W-1:0] w_sh;

    logic  r2_v;
    t_op   r2_op;
    t_word r2_val;
    logic  r2_lt;
    logic  r2_ltu;
    logic  r2_eq;
    logic [2:0] r2_f3;
    logic  r2_clr0;
    logic  r2_ill;

    // Stage 3 select
    t_word n3_res;
    logic  n3_taken;

    logic  r3_v;
    t_word r3_res;
    logic  r3_taken;
    logic  r3_ill;

    assign w_f3     = s_axis_tdata[2:0];
    assign w_f7     = s_axis_tdata[9:3];
    assign w_src1   = s_axis_tdata[41:10];
    assign w_src2   = s_axis_tdata[73:42];
    assign w_imm    = s_axis_tdata[105:74];
    assign w_pc     = s_axis_tdata[137:106];
    assign w_opcode = s_axis_tuser;
    assign w_upper  = w_imm << UPPER_SHIFT;

    // Advance every stage together whenever the output slot frees up
    assign w_en          = !r3_v || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        n1_op   = OP_ZERO;
        n1_a    = w_src1;
        n1_b    = w_imm;
        n1_clr0 = 1'b0;
        n1_ill  = 1'b0;
        unique case (w_opcode)
            CLS_REG: begin
                n1_b = w_src2;
                if (w_f7 == F7_BASE) begin
                    unique case (w_f3)
                        F3_ADD:  n1_op = OP_ADD;
                        F3_SLL:  n1_op = OP_SLL;
                        F3_SLT:  n1_op = OP_SLT;
                        F3_SLTU: n1_op = OP_SLTU;
                        F3_XOR:  n1_op = OP_XOR;
                        F3_SR:   n1_op = OP_SRL;
                        F3_OR:   n1_op = OP_OR;
                        default: n1_op = OP_AND;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == F3_ADD) begin
                    n1_op = OP_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == F3_SR) begin
                    n1_op = OP_SRA;
                end else begin
                    n1_ill = 1'b1;
                end
            end
            CLS_IMM: begin
                unique case (w_f3)
                    F3_ADD:  n1_op = OP_ADD;
                    F3_SLL:  n1_op = OP_SLL;
                    F3_SLT:  n1_op = OP_SLT;
                    F3_SLTU: n1_op = OP_SLTU;
                    F3_XOR:  n1_op = OP_XOR;
                    F3_SR:   n1_op = (w_imm[11:5] == F7_ALT) ? OP_SRA : OP_SRL;
                    F3_OR:   n1_op = OP_OR;
                    default: n1_op = OP_AND;
                endcase
            end
            CLS_LOAD: begin
                if (w_f3 == F3_LD_BAD || w_f3 == F3_LD_BAD6 || w_f3 == F3_LD_BAD7) begin
                    n1_ill = 1'b1;
                end else begin
                    n1_op = OP_ADD;
                end
            end
            CLS_JALR: begin
                n1_op   = OP_ADD;
                n1_clr0 = 1'b1;
            end
            CLS_SYSTEM: begin
                n1_op = OP_ZERO;
            end
            CLS_BRANCH: begin
                n1_b = w_src2;
                unique case (w_f3)
                    F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU: n1_op = OP_BRANCH;
                    default: n1_ill = 1'b1;
                endcase
            end
            CLS_LUI: begin
                n1_op = OP_ADD;
                n1_a  = '0;
                n1_b  = w_upper;
            end
            default: begin
                n1_op = OP_ADD;
                n1_a  = w_pc;
                n1_b  = w_upper;
            end
        endcase
    end

    assign w_sh  = r1_b[SHAMT_W-1:0];
    assign w_sum = (r1_op == OP_SUB) ? (r1_a - r1_b) : (r1_a + r1_b);

    always_comb begin
        unique case (r1_op)
            OP_ADD, OP_SUB: n2_val = w_sum;
            OP_SLL:         n2_val = r1_a << w_sh;
            OP_SRL:         n2_val = r1_a >> w_sh;
            OP_SRA:         n2_val = t_word'($signed(r1_a) >>> w_sh);
            OP_XOR:         n2_val = r1_a ^ r1_b;
            OP_OR:          n2_val = r1_a | r1_b;
            OP_AND:         n2_val = r1_a & r1_b;
            default:        n2_val = '0;
        endcase
    end

    always_comb begin
        n3_taken = 1'b0;
        unique case (r2_op)
            OP_SLT:  n3_res = {{(XLEN-1){1'b0}}, r2_lt};
            OP_SLTU: n3_res = {{(XLEN-1){1'b0}}, r2_ltu};
            default: n3_res = r2_val;
        endcase
        if (r2_clr0) begin
            n3_res[0] = 1'b0;
        end
        if (r2_op == OP_BRANCH) begin
            unique case (r2_f3)
                F3_BEQ:  n3_taken = r2_eq;
                F3_BNE:  n3_taken = !r2_eq;
                F3_BLT:  n3_taken = r2_lt;
                F3_BGE:  n3_taken = !r2_lt;
                F3_BLTU: n3_taken = r2_ltu;
                F3_BGEU: n3_taken = !r2_ltu;
                default: n3_taken = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op    <= n1_op;
            r1_a     <= n1_a;
            r1_b     <= n1_b;
            r1_f3    <= w_f3;
            r1_clr0  <= n1_clr0;
            r1_ill   <= n1_ill;

            r2_op    <= r1_op;
            r2_val   <= n2_val;
            r2_lt    <= $signed(r1_a) < $signed(r1_b);
            r2_ltu   <= r1_a < r1_b;
            r2_eq    <= r1_a == r1_b;
            r2_f3    <= r1_f3;
            r2_clr0  <= r1_clr0;
            r2_ill   <= r1_ill;

            r3_res   <= n3_res;
            r3_taken <= n3_taken;
            r3_ill   <= r2_ill;
        end
    end

    assign m_axis_tvalid = r3_v;
    assign m_axis_tdata  = r3_res;
    assign m_axis_tuser  = {r3_ill, r3_taken};

`ifndef NO_ASSERTIONS
    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
        else $error("illegal result carries nonzero payload");

    a_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("taken branch carries nonzero result");

    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready)
            ##1 (r1_v && m_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item lost in pipeline");
`endif

endmodule
